>>> rtl/derenc_pkg.sv
// Package for the DER header and integer encoder: opcodes, DER constants,
// the command word passed from front to back, and the byte-order helper.
// No dependencies.
`timescale 1ns / 1ps

package derenc_pkg;

  // Request opcodes carried on the input tuser.
  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_INT    = 2'd1,
    OP_NULL   = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  localparam logic [7:0] TAG_INTEGER   = 8'h02;
  localparam logic [7:0] TAG_NULL      = 8'h05;
  localparam logic [7:0] LEN_ZERO      = 8'h00;
  localparam logic [7:0] LEN_LONG_FORM = 8'h80;
  localparam logic [4:0] HIGH_TAG_FORM = 5'h1F;

  localparam int MAX_BYTES = 6;
  localparam int CNT_W     = 3;

  // Queue depth must be a power of two so that the pointers wrap freely.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One encoded request: up to six bytes, first byte in element 0.
  typedef struct packed {
    logic                           err;
    logic [CNT_W-1:0]               cnt;
    logic [MAX_BYTES-1:0][7:0]      bytes;
  } cmd_t;

  // The low n bytes of w in big-endian order, first emitted byte lowest.
  function automatic logic [3:0][7:0] be_bytes(input logic [31:0] w,
                                               input logic [2:0]  n);
    logic [3:0][7:0] r;
    r = '0;
    unique case (n)
      3'd1: r[0] = w[7:0];
      3'd2: begin
        r[0] = w[15:8];
        r[1] = w[7:0];
      end
      3'd3: begin
        r[0] = w[23:16];
        r[1] = w[15:8];
        r[2] = w[7:0];
      end
      3'd4: begin
        r[0] = w[31:24];
        r[1] = w[23:16];
        r[2] = w[15:8];
        r[3] = w[7:0];
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/derenc_front.sv
// Front end of the DER encoder: accepts requests, builds the full byte
// image and count of each one, and holds it in a stage register.
// Depends on derenc_pkg.
`timescale 1ns / 1ps

module derenc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [71:0]        in_tdata,
  input  logic [1:0]         in_tuser,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output derenc_pkg::cmd_t   cmd
);
  import derenc_pkg::*;

  logic [7:0]  tag;
  logic [31:0] length;
  logic [31:0] int_value;
  logic [31:0] mag;
  logic [2:0]  nlen;
  logic [2:0]  icnt;
  logic [3:0][7:0] len_be;
  logic [3:0][7:0] int_be;
  cmd_t        cmd_nxt;
  cmd_t        cmd_r;
  logic        valid_r;

  assign tag       = in_tdata[7:0];
  assign length    = in_tdata[39:8];
  assign int_value = in_tdata[71:40];

  // Magnitude in the sense of minimal two's-complement width.
  assign mag = int_value ^ {32{int_value[31]}};

  always_comb begin
    if (length[31:24] != 8'd0)      nlen = 3'd4;
    else if (length[23:16] != 8'd0) nlen = 3'd3;
    else if (length[15:8] != 8'd0)  nlen = 3'd2;
    else                            nlen = 3'd1;

    if (mag[31:7] == 25'd0)       icnt = 3'd1;
    else if (mag[31:15] == 17'd0) icnt = 3'd2;
    else if (mag[31:23] == 9'd0)  icnt = 3'd3;
    else                          icnt = 3'd4;
  end

  assign len_be = be_bytes(length, nlen);
  assign int_be = be_bytes(int_value, icnt);

  always_comb begin
    cmd_nxt = '0;
    unique case (op_t'(in_tuser))
      OP_HEADER: begin
        if (tag[4:0] == HIGH_TAG_FORM) begin
          cmd_nxt.err = 1'b1;
          cmd_nxt.cnt = 3'd1;
        end else if (length[31:7] == 25'd0) begin
          cmd_nxt.cnt      = 3'd2;
          cmd_nxt.bytes[0] = tag;
          cmd_nxt.bytes[1] = length[7:0];
        end else begin
          cmd_nxt.cnt        = 3'd2 + nlen;
          cmd_nxt.bytes[0]   = tag;
          cmd_nxt.bytes[1]   = LEN_LONG_FORM | {5'd0, nlen};
          cmd_nxt.bytes[5:2] = len_be;
        end
      end
      OP_INT: begin
        cmd_nxt.cnt        = 3'd2 + icnt;
        cmd_nxt.bytes[0]   = TAG_INTEGER;
        cmd_nxt.bytes[1]   = {5'd0, icnt};
        cmd_nxt.bytes[5:2] = int_be;
      end
      OP_NULL: begin
        cmd_nxt.cnt      = 3'd2;
        cmd_nxt.bytes[0] = TAG_NULL;
        cmd_nxt.bytes[1] = LEN_ZERO;
      end
      OP_RSVD: begin
        cmd_nxt.err = 1'b1;
        cmd_nxt.cnt = 3'd1;
      end
      default: cmd_nxt = '0;
    endcase
  end

  assign in_tready = !valid_r || cmd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      cmd_r <= cmd_nxt;
    end
  end

  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

endmodule

>>> rtl/derenc_queue.sv
// Short command queue between the front and back of the DER encoder.
// Depends on derenc_pkg.
`timescale 1ns / 1ps

module derenc_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  derenc_pkg::cmd_t   push_cmd,
  output logic               pop_valid,
  input  logic               pop,
  output derenc_pkg::cmd_t   head
);
  import derenc_pkg::*;

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign head       = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

>>> rtl/derenc_back.sv
// Back end of the DER encoder: walks the queued command one byte per
// unstalled cycle into a registered output. Depends on derenc_pkg.
`timescale 1ns / 1ps

module derenc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  input  derenc_pkg::cmd_t   cmd,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  output logic               out_tlast,
  output logic [0:0]         out_tuser
);
  import derenc_pkg::*;

  logic [CNT_W-1:0] idx_r;
  logic [7:0]       cur_byte;
  logic             is_last;
  logic             advance;
  logic             emit;
  logic             valid_r;
  logic [7:0]       byte_r;
  logic             last_r;
  logic             err_r;

  always_comb begin
    unique case (idx_r)
      3'd0:    cur_byte = cmd.bytes[0];
      3'd1:    cur_byte = cmd.bytes[1];
      3'd2:    cur_byte = cmd.bytes[2];
      3'd3:    cur_byte = cmd.bytes[3];
      3'd4:    cur_byte = cmd.bytes[4];
      3'd5:    cur_byte = cmd.bytes[5];
      default: cur_byte = 8'd0;
    endcase
  end

  assign is_last = (idx_r == cmd.cnt - 3'd1);
  assign advance = !valid_r || out_tready;
  assign emit    = advance && cmd_valid;
  assign cmd_pop = emit && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      if (advance) valid_r <= cmd_valid;
      if (emit) idx_r <= is_last ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      byte_r <= cur_byte;
      last_r <= is_last;
      err_r  <= cmd.err;
    end
  end

  assign out_tvalid   = valid_r;
  assign out_tdata    = byte_r;
  assign out_tlast    = last_r;
  assign out_tuser[0] = err_r;

endmodule

>>> rtl/der_header_and_integer_encoder.sv
// DER header and integer encoder. A request passes the front stage register,
// then the queue write, then the output register before its first byte is
// valid. Throughput: one byte per cycle while out_tready is high; a request
// yields n bytes (1 to 6), and requests are taken every cycle while the
// two-entry queue has room.
// Reset (synchronous, rst_n low) empties the stage, queue and output.
`timescale 1ns / 1ps

module der_header_and_integer_encoder (
  input  logic        clk,
  input  logic        rst_n,
  // Request word.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // tag [7:0], length [39:8], int_value [71:40]
  input  logic [1:0]  in_tuser,   // op [1:0]: header, integer, null
  // Encoded byte word.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // out_byte [7:0]
  output logic        out_tlast,  // set on the final byte of a request
  output logic [0:0]  out_tuser   // error [0]: request rejected
);
  import derenc_pkg::*;

  // The front end turns each request into a complete byte image with its
  // count, so the back end only has to walk bytes. Rejected requests (high
  // tag form in header mode, or the unused opcode) become a single zero
  // byte with the error flag.
  logic fq_valid;
  logic fq_ready;
  cmd_t fq_cmd;
  logic qb_valid;
  logic qb_pop;
  cmd_t qb_cmd;

  derenc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd       (fq_cmd)
  );

  // The queue lets the front keep accepting while a long request drains.
  derenc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_cmd   (fq_cmd),
    .pop_valid  (qb_valid),
    .pop        (qb_pop),
    .head       (qb_cmd)
  );

  // The back end emits one byte per cycle when not stalled and pops the
  // command on its last byte, so consecutive requests follow without a gap.
  derenc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (qb_valid),
    .cmd_pop    (qb_pop),
    .cmd        (qb_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

>>> tb/sv/der_octet_checker.sv
// Checker for the DER header and integer encoder: watches both streams,
// predicts the encoded octets of each accepted request and compares them.
// Depends on derenc_pkg for the opcodes and DER constants.
`timescale 1ns / 1ps

module der_octet_checker
  import derenc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic        out_tlast,
  input  logic [0:0]  out_tuser,
  output int          mismatches,
  output int          octets_awaited
);

  typedef struct packed {
    logic [7:0] octet;
    logic       last;
    logic       err;
  } der_word_t;

  der_word_t  awaited_words[$];
  logic [7:0] octet_buf[$];
  int         word_index;

  initial begin
    mismatches     = 0;
    octets_awaited = 0;
    word_index     = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch on output word %0d: %s", $realtime, word_index, what);
    mismatches++;
  endtask

  // Identifier octet, then the definite length in short or long form.
  function automatic void push_tag_and_length(input logic [7:0] tag, input logic [31:0] len);
    int nlen;
    octet_buf.push_back(tag);
    if (len < 32'h80) begin
      octet_buf.push_back(len[7:0]);
    end else begin
      if (len[31:24] != 8'h00) nlen = 4;
      else if (len[23:16] != 8'h00) nlen = 3;
      else if (len[15:8] != 8'h00) nlen = 2;
      else nlen = 1;
      octet_buf.push_back(LEN_LONG_FORM | 8'(nlen));
      for (int i = nlen; i > 0; i--) octet_buf.push_back(len[8*(i-1) +: 8]);
    end
  endfunction

  function automatic void predict_encoding(input op_t op, input logic [7:0] tag,
                                           input logic [31:0] len, input logic [31:0] val);
    der_word_t   w;
    logic [31:0] mag;
    int          cnt;
    octet_buf.delete();
    if (op == OP_RSVD || (op == OP_HEADER && tag[4:0] == HIGH_TAG_FORM)) begin
      w.octet = 8'h00;
      w.last  = 1'b1;
      w.err   = 1'b1;
      awaited_words.push_back(w);
      return;
    end
    case (op)
      OP_HEADER: push_tag_and_length(tag, len);
      OP_INT: begin
        // Negative values fold onto their one's complement to size the octets.
        mag = val ^ {32{val[31]}};
        if (mag < 32'h80) cnt = 1;
        else if (mag < 32'h8000) cnt = 2;
        else if (mag < 32'h80_0000) cnt = 3;
        else cnt = 4;
        push_tag_and_length(TAG_INTEGER, 32'(cnt));
        for (int i = cnt; i > 0; i--) octet_buf.push_back(val[8*(i-1) +: 8]);
      end
      default: begin
        octet_buf.push_back(TAG_NULL);
        octet_buf.push_back(LEN_ZERO);
      end
    endcase
    foreach (octet_buf[k]) begin
      w.octet = octet_buf[k];
      w.last  = (k == octet_buf.size() - 1);
      w.err   = 1'b0;
      awaited_words.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    der_word_t want;
    if (!rst_n) begin
      awaited_words.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        predict_encoding(op_t'(in_tuser), in_tdata[7:0], in_tdata[39:8], in_tdata[71:40]);
      end
      if (out_tvalid && out_tready) begin
        if (awaited_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %02h last %b error %b",
                                    out_tdata, out_tlast, out_tuser[0]));
        end else begin
          want = awaited_words.pop_front();
          if (out_tdata !== want.octet)
            report_mismatch($sformatf("byte %02h, expected %02h", out_tdata, want.octet));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("last %b, expected %b", out_tlast, want.last));
          if (out_tuser[0] !== want.err)
            report_mismatch($sformatf("error %b, expected %b", out_tuser[0], want.err));
        end
        word_index++;
      end
    end
    octets_awaited <= awaited_words.size();
  end

endmodule

>>> tb/sv/tb_der_header_and_integer_encoder.sv
// Top of the testbench for the DER header and integer encoder: drives
// directed and random requests, paces the output side and gives the verdict.
// Depends on derenc_pkg, der_octet_checker and the encoder itself.
`timescale 1ns / 1ps

module tb_der_header_and_integer_encoder;
  import derenc_pkg::*;

  // The slowest legal run is a few hundred requests of up to six words, each
  // word waiting out a long receiver stall; this bound leaves a wide margin.
  localparam int LIMIT_CYCLES = 400000;
  localparam int LONG_STALL   = 200;
  // Settle time after a drain, long enough for a request to pass the front
  // stage, queue and output register of the encoder.
  localparam int SETTLE       = 12;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = OP_HEADER;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic [0:0]  out_tuser;

  int mismatches;
  int octets_awaited;
  int cycles = 0;

  // Pacing controls for the sender and the receiver processes.
  bit sender_quiet   = 1'b0;
  bit receiver_quiet = 1'b0;
  bit stall_request  = 1'b0;

  always #4 clk = ~clk;

  der_header_and_integer_encoder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  der_octet_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .out_tuser     (out_tuser),
    .mismatches    (mismatches),
    .octets_awaited(octets_awaited)
  );

  // Idle gaps are mostly absent or short, with an occasional long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offers one request word, holds it until the encoder takes it, then idles
  // for a random gap. Valid stays high across back-to-back words.
  task automatic send_request(input op_t op, input logic [7:0] tag,
                              input logic [31:0] len, input logic [31:0] val);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {val, len, tag};
    do @(posedge clk); while (!in_tready);
    gap = sender_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering until every predicted word has come out, then lets the
  // pipeline settle.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (octets_awaited != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Random request. Lengths and values are drawn by size class so that every
  // length form and every integer width shows up often, including the
  // boundaries where one more octet is needed.
  task automatic send_random_request();
    op_t         op;
    logic [7:0]  tag;
    logic [31:0] len;
    logic [31:0] val;
    int          r;
    r = $urandom_range(0, 99);
    if (r < 35) op = OP_HEADER;
    else if (r < 75) op = OP_INT;
    else if (r < 92) op = OP_NULL;
    else op = OP_RSVD;
    tag = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0: len = $urandom_range(0, 127);
      1: len = $urandom_range(128, 255);
      2: len = $urandom_range(256, 16'hFFFF);
      3: len = $urandom_range(32'h1_0000, 32'hFF_FFFF);
      4: len = $urandom | 32'h0100_0000;
      default: len = $urandom;
    endcase
    val = $urandom >> $urandom_range(0, 31);
    if ($urandom_range(0, 1)) val = ~val;
    send_request(op, tag, len, val);
  endtask

  // Output side. Ready runs high for a random stretch and then drops for a
  // random gap; on request it holds off for a long stretch on its own count.
  initial begin
    int run;
    int gap;
    wait (rst_n === 1'b1);
    forever begin
      if (stall_request) begin
        out_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        stall_request = 1'b0;
      end
      out_tready <= 1'b1;
      run = $urandom_range(1, 8);
      repeat (run) @(posedge clk);
      gap = receiver_quiet ? 0 : pick_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: length forms at each boundary, tag extremes, the
    // high-tag rejection, integer widths at each sign boundary, null and the
    // unused opcode. Fields that a mode ignores carry junk.
    send_request(OP_HEADER, 8'h00, 32'd0,          32'hDEAD_BEEF);
    send_request(OP_HEADER, 8'h30, 32'd127,        32'h0);
    send_request(OP_HEADER, 8'hFE, 32'd128,        32'hFFFF_FFFF);
    send_request(OP_HEADER, 8'h04, 32'd255,        32'h0);
    send_request(OP_HEADER, 8'hA0, 32'd256,        32'h0);
    send_request(OP_HEADER, 8'h16, 32'h0000_FFFF,  32'h0);
    send_request(OP_HEADER, 8'h31, 32'h0001_0000,  32'h0);
    send_request(OP_HEADER, 8'h60, 32'h0100_0000,  32'h0);
    send_request(OP_HEADER, 8'hC0, 32'hFFFF_FFFF,  32'h0);
    send_request(OP_HEADER, 8'h1F, 32'd5,          32'h0);
    send_request(OP_HEADER, 8'hFF, 32'hFFFF_FFFF,  32'h0);
    send_request(OP_INT,    8'h1F, 32'hFFFF_FFFF,  32'd0);
    send_request(OP_INT,    8'h00, 32'h0,          32'd127);
    send_request(OP_INT,    8'h00, 32'h0,          32'd128);
    send_request(OP_INT,    8'h00, 32'h0,          -32'sd128);
    send_request(OP_INT,    8'h00, 32'h0,          -32'sd129);
    send_request(OP_INT,    8'h00, 32'h0,          32'd32768);
    send_request(OP_INT,    8'h00, 32'h0,          -32'sd32769);
    send_request(OP_INT,    8'h00, 32'h0,          32'h0080_0000);
    send_request(OP_INT,    8'h00, 32'h0,          -32'sh0080_0001);
    send_request(OP_INT,    8'h00, 32'h0,          32'h7FFF_FFFF);
    send_request(OP_INT,    8'h00, 32'h0,          32'h8000_0000);
    send_request(OP_NULL,   8'h1F, 32'hFFFF_FFFF,  32'hFFFF_FFFF);
    send_request(OP_RSVD,   8'h02, 32'd1,          32'd1);

    // Let everything out before the back-pressure test.
    wait_for_drain();

    // The receiver holds off while the sender offers words back to back, so
    // the queue fills and the encoder has to drop its input ready.
    stall_request = 1'b1;
    sender_quiet  = 1'b1;
    repeat (30) send_random_request();
    sender_quiet  = 1'b0;

    // Random part in four phases; the third runs with no idling on either
    // side, and the sender pauses for a full drain after the second.
    for (int phase = 0; phase < 4; phase++) begin
      sender_quiet   = (phase == 2);
      receiver_quiet = (phase == 2);
      repeat (80) send_random_request();
      if (phase == 1) wait_for_drain();
    end
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;

    wait_for_drain();

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
